>>> rtl/dlt_pkg.sv
// Shared types, constants and calendar helpers for the DST local time converter.
// Used by dlt_ctrl, dlt_dp and the top level; depends on nothing else.
`default_nettype none
package dlt_pkg;

	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned MIN_SECS  = 60;
	localparam int unsigned DAY_MINS  = 24 * 60;

	// day count = ((utc >> 7) * DAY_RECIP) >> 35, exact for every 25 bit operand
	localparam logic [25:0] DAY_RECIP = 26'd50903317;

	// 1970-01-01 was a Thursday; residues of 1970 for the leap rule
	localparam logic [2:0] EPOCH_DOW  = 3'd4;
	localparam logic [1:0] EPOCH_Y4   = 2'd2;
	localparam logic [6:0] EPOCH_Y100 = 7'd70;
	localparam logic [8:0] EPOCH_Y400 = 9'd370;

	localparam logic signed [10:0] OFF_MIN = -11'sd720;
	localparam logic signed [10:0] OFF_MAX = 11'sd840;

	// configuration register indexes
	localparam logic [2:0] REG_STD_OFFSET = 3'd0;
	localparam logic [2:0] REG_DST_OFFSET = 3'd1;
	localparam logic [2:0] REG_DST_ENABLE = 3'd2;
	localparam logic [2:0] REG_DST_START  = 3'd3;
	localparam logic [2:0] REG_DST_END    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_YEAR, S_RINIT, S_MONTH, S_DAY, S_MUL, S_ADD,
		S_TOD, S_HOUR, S_MIN, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DIV, OP_YEAR, OP_RINIT, OP_MONTH, OP_DAY, OP_MUL,
		OP_ADD, OP_TOD, OP_HOUR, OP_MIN, OP_PUSH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic rule;     // 0 start rule, 1 end rule
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic year_done;
		logic month_done;
		logic hour_done;
		logic min_done;
		logic out_free;
	} status_t;

	// days in month m (1..12); codes outside that range give 31
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		unique case (m)
			4'd2: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dlt_ctrl.sv
// Sequencer of the DST local time converter: steps the datapath through
// division, year walk, both rules and the time split. Uses dlt_pkg.
`default_nettype none
module dlt_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  dlt_pkg::status_t sts,
	output dlt_pkg::cmd_t    cmd
);
	import dlt_pkg::*;

	state_t state_q, state_nx;
	logic   rule_q;

	// state and rule select registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rule_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE)
				rule_q <= 1'b0;
			else if (state_q == S_ADD)
				rule_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_nx = S_DIV;
			S_DIV:   if (sts.div_last) state_nx = S_YEAR;
			S_YEAR:  if (sts.year_done) state_nx = S_RINIT;
			S_RINIT: state_nx = S_MONTH;
			S_MONTH: if (sts.month_done) state_nx = S_DAY;
			S_DAY:   state_nx = S_MUL;
			S_MUL:   state_nx = S_ADD;
			S_ADD:   state_nx = rule_q ? S_TOD : S_RINIT;
			S_TOD:   state_nx = S_HOUR;
			S_HOUR:  if (sts.hour_done) state_nx = S_MIN;
			S_MIN:   if (sts.min_done) state_nx = S_FIN;
			S_FIN:   if (sts.out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready = 1'b0;
		cmd.rule = rule_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_DIV:   cmd.op = OP_DIV;
			S_YEAR:  cmd.op = OP_YEAR;
			S_RINIT: cmd.op = OP_RINIT;
			S_MONTH: cmd.op = OP_MONTH;
			S_DAY:   cmd.op = OP_DAY;
			S_MUL:   cmd.op = OP_MUL;
			S_ADD:   cmd.op = OP_ADD;
			S_TOD:   cmd.op = OP_TOD;
			S_HOUR:  cmd.op = OP_HOUR;
			S_MIN:   cmd.op = OP_MIN;
			S_FIN:   if (sts.out_free) cmd.op = OP_PUSH;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/dlt_dp.sv
// Datapath of the DST local time converter: configuration registers, calendar
// arithmetic and the output word register. Driven by dlt_ctrl; uses dlt_pkg.
`default_nettype none
module dlt_dp (
	input  wire              clk,
	input  wire              arst_n,
	input  dlt_pkg::cmd_t    cmd,
	output dlt_pkg::status_t sts,
	input  wire              cfg_we,
	input  wire  [2:0]       cfg_index,
	input  wire  [20:0]      cfg_data,
	input  wire  [31:0]      in_utc,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [31:0]      out_data,
	output logic             out_dst
);
	import dlt_pkg::*;

	// configuration
	logic signed [10:0] std_q, dst_q;
	logic               en_q;
	logic [20:0]        start_q, end_q;

	// working registers
	logic [31:0] utc_q;
	logic [31:0] rem_q;
	logic [15:0] days_q;
	logic        cnt_q;
	logic [15:0] d_q, yday0_q, first_q, daynum_q;
	logic [2:0]  ydow_q, dow_q;
	logic [1:0]  y4_q;
	logic [6:0]  y100_q;
	logic [8:0]  y400_q;
	logic [3:0]  m_q;
	logic [32:0] prod_q;
	logic signed [18:0] mterm_q;
	logic [33:0] s_q, e_q;
	logic        sv_q, ev_q, act_q;
	logic signed [10:0] off_q;
	logic [16:0] tod_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;

	// output register
	logic        ovalid_q, odst_q;
	logic [31:0] odata_q;

	// combinational helpers
	logic               leap, en_w, rule_ok, active_w;
	logic [20:0]        rule_w;
	logic [3:0]         r_mon;
	logic [2:0]         r_wk, r_wd;
	logic [10:0]        r_mins;
	logic signed [10:0] r_off, off_w;
	logic [50:0]        recip_w;
	logic [31:0]        daysec_w;
	logic [8:0]         yl;
	logic [3:0]         ydow_sum;
	logic [4:0]         dim_m, dim_r;
	logic [3:0]         dow_sum, wd_x;
	logic [5:0]         day_a, day_w;
	logic [32:0]        prod_w;
	logic signed [18:0] mt_w;
	logic signed [35:0] t_w;
	logic signed [16:0] offm_w;
	logic signed [18:0] sum_w;
	logic [16:0]        tod_w;
	logic [33:0]        utc_x;

	assign leap    = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
	assign yl      = leap ? 9'd366 : 9'd365;
	assign en_w    = en_q && (dst_q != std_q) && (dst_q >= OFF_MIN) && (dst_q <= OFF_MAX);

	// day count and second of the day
	assign recip_w  = 51'(utc_q[31:7]) * 51'(DAY_RECIP);
	assign daysec_w = 32'(days_q) * 32'(DAY_SECS);

	// weekday of next 1st January
	assign ydow_sum = 4'(ydow_q) + (leap ? 4'd2 : 4'd1);

	// selected rule fields
	assign rule_w  = cmd.rule ? end_q : start_q;
	assign r_off   = cmd.rule ? dst_q : std_q;
	assign r_mon   = rule_w[3:0];
	assign r_wk    = rule_w[6:4];
	assign r_wd    = rule_w[9:7];
	assign r_mins  = rule_w[20:10];
	assign rule_ok = (r_mon >= 4'd1) && (r_mon <= 4'd12) && (r_wk >= 3'd1) &&
		(r_wk <= 3'd5) && (r_wd <= 3'd6) && (r_mins < 11'(DAY_MINS));

	// month walk and weekday of the first
	assign dim_m   = month_days(m_q, leap);
	assign dow_sum = 4'(dow_q) + 4'(dim_m - 5'd28);
	assign dim_r   = month_days(r_mon, leap);
	assign wd_x    = (4'(r_wd) + 4'd7 - 4'(dow_q) >= 4'd7) ?
		4'(r_wd) - 4'(dow_q) : 4'(r_wd) + 4'd7 - 4'(dow_q);
	assign day_a   = 6'd1 + 6'(wd_x) + 6'(3'(r_wk - 3'd1)) * 6'd7;
	assign day_w   = (day_a > 6'(dim_r)) ? day_a - 6'd7 : day_a;

	// transition instant
	assign prod_w = 33'(daynum_q) * 33'(DAY_SECS);
	assign mt_w   = 19'($signed({2'b00, r_mins})) - 19'(r_off);
	assign t_w    = $signed({3'b000, prod_q}) + 36'(mterm_q);

	// decision and local time of day
	assign utc_x    = {2'b00, utc_q};
	assign active_w = en_w && sv_q && ev_q &&
		((s_q < e_q) ? (utc_x >= s_q && utc_x < e_q) : (utc_x >= s_q || utc_x < e_q));
	assign off_w    = active_w ? dst_q : std_q;
	assign offm_w   = 17'(off_w) * 17'sd60;
	assign sum_w    = $signed({2'b00, rem_q[16:0]}) + 19'(offm_w);
	assign tod_w    = sum_w[18] ? 17'(sum_w + 19'sd86400) :
		(sum_w >= 19'sd86400) ? 17'(sum_w - 19'sd86400) : sum_w[16:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q   <= '0;
			dst_q   <= '0;
			en_q    <= 1'b0;
			start_q <= '0;
			end_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STD_OFFSET: std_q   <= $signed(cfg_data[10:0]);
				REG_DST_OFFSET: dst_q   <= $signed(cfg_data[10:0]);
				REG_DST_ENABLE: en_q    <= cfg_data[0];
				REG_DST_START:  start_q <= cfg_data;
				REG_DST_END:    end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// arithmetic steps
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				utc_q <= in_utc;
				cnt_q <= 1'b1;
			end
			OP_DIV: begin
				// with cnt_q set: day count by reciprocal; once it clears: second of the day
				if (cnt_q) begin
					days_q <= recip_w[50:35];
				end else begin
					rem_q <= utc_q - daysec_w;
					d_q   <= days_q;
				end
				cnt_q   <= 1'b0;
				yday0_q <= '0;
				ydow_q  <= EPOCH_DOW;
				y4_q    <= EPOCH_Y4;
				y100_q  <= EPOCH_Y100;
				y400_q  <= EPOCH_Y400;
			end
			OP_YEAR: begin
				// one year per cycle
				if (d_q >= 16'(yl)) begin
					d_q     <= d_q - 16'(yl);
					yday0_q <= yday0_q + 16'(yl);
					ydow_q  <= (ydow_sum >= 4'd7) ? 3'(ydow_sum - 4'd7) : ydow_sum[2:0];
					y4_q    <= y4_q + 2'd1;
					y100_q  <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
					y400_q  <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
				end
			end
			OP_RINIT: begin
				m_q     <= 4'd1;
				first_q <= yday0_q;
				dow_q   <= ydow_q;
			end
			OP_MONTH: begin
				if (!sts.month_done) begin
					first_q <= first_q + 16'(dim_m);
					dow_q   <= (dow_sum >= 4'd7) ? 3'(dow_sum - 4'd7) : dow_sum[2:0];
					m_q     <= m_q + 4'd1;
				end
			end
			OP_DAY: daynum_q <= first_q + 16'(day_w) - 16'd1;
			OP_MUL: begin
				prod_q  <= prod_w;
				mterm_q <= 19'(mt_w * 19'sd60);
			end
			OP_ADD: begin
				if (cmd.rule) begin
					e_q  <= t_w[33:0];
					ev_q <= rule_ok && !t_w[35] && (t_w != 36'sd0);
				end else begin
					s_q  <= t_w[33:0];
					sv_q <= rule_ok && !t_w[35] && (t_w != 36'sd0);
				end
			end
			OP_TOD: begin
				act_q  <= active_w;
				off_q  <= off_w;
				tod_q  <= tod_w;
				hour_q <= '0;
				min_q  <= '0;
			end
			OP_HOUR: begin
				if (!sts.hour_done) begin
					tod_q  <= tod_q - 17'(HOUR_SECS);
					hour_q <= hour_q + 5'd1;
				end
			end
			OP_MIN: begin
				if (!sts.min_done) begin
					tod_q <= tod_q - 17'(MIN_SECS);
					min_q <= min_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.op == OP_PUSH)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH) begin
			odata_q <= {4'b0000, off_q, tod_q[5:0], min_q, hour_q};
			odst_q  <= act_q;
		end
	end

	// status to the sequencer
	assign sts.div_last   = (cnt_q == 1'b0);
	assign sts.year_done  = (d_q < 16'(yl));
	assign sts.month_done = (m_q >= r_mon) || (m_q == 4'd12);
	assign sts.hour_done  = (tod_q < 17'(HOUR_SECS));
	assign sts.min_done   = (tod_q < 17'(MIN_SECS));
	assign sts.out_free   = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_dst   = odst_q;

endmodule
`default_nettype wire

>>> rtl/dst_local_time_converter.sv
// DST local time converter: top level joining sequencer and datapath.
// Depends on dlt_pkg, dlt_ctrl and dlt_dp.
//
// Use: software writes the five registers over the cfg channel (index 0 std
// offset, 1 DST offset, 2 enable, 3 start rule, 4 end rule; cfg_ready is
// always high), then sends UTC seconds words on s_axis. Each input word gives
// one result word on m_axis: local hour, minute, second and the offset in
// tdata, the DST flag in tuser.
// One word is worked on at a time; s_axis_tready is high only while idle.
// After the input is taken, the block finds the day count and second of the
// day, walks the years since 1970, walks the months up to each rule's month
// and forms each rule's transition instant, takes the time of day, steps off
// the hours and minutes and loads the output; m_axis_tvalid then rises. The
// next word can be taken in the cycle in which m_axis_tvalid rises.
// The result sits in an output register; a new word is taken while it waits,
// and when m_axis stalls the finished next result waits until the register
// frees. Reset clears the configuration registers to zero, DST disabled, and
// empties the output.
`default_nettype none
module dst_local_time_converter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [20:0] cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [31:0] UTC second count
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [4:0] local_hour, [10:5] local_minute,
	                                    // [16:11] local_second, [27:17] utc offset
	output logic        m_axis_tuser    // [0] dst_active
);
	import dlt_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	dlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dlt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_utc    (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_dst   (m_axis_tuser)
	);

endmodule
`default_nettype wire

>>> rtl/dlt_checker.sv
// Port-level checks for the DST local time converter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module dlt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire        m_axis_tuser
);

	// a stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// time of day fields in range
	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'd23) &&
			(m_axis_tdata[10:5] <= 6'd59) && (m_axis_tdata[16:11] <= 6'd59))
		else $error("time of day out of range");

	// DST offset is only applied when it lies in the legal range
	a_dst_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			($signed(m_axis_tdata[27:17]) >= -11'sd720) &&
			($signed(m_axis_tdata[27:17]) <= 11'sd840))
		else $error("DST flagged with illegal offset");

endmodule

bind dst_local_time_converter dlt_checker u_dlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> sim/dlt_checker.sv
// Checker for the DST local time converter: watches the input, config and result
// channels, predicts each result and compares it. Depends on dlt_pkg.
`timescale 1ns / 1ps
module dlt_scoreboard import dlt_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [20:0] cfg_data,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [31:0] s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,
	input  wire         m_tuser,
	output int          fail_count,
	output int          pending,
	output int          dst_hits
);

	typedef struct packed {
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic signed [10:0] offset;
		logic               active;
	} local_time_t;

	logic signed [10:0] std_off, dst_off;
	logic               dst_en;
	logic [20:0]        rule_on, rule_off;
	local_time_t        expected_times[$];

	function automatic bit leap_year(input longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint month_len(input longint y, input int m);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// UTC second of a rule's transition in the given year; 0 means none
	function automatic longint rule_utc(input longint year, input longint jan1,
			input logic [20:0] rule, input longint off);
		int     mon, wk, wd, mins, dow1, day, dim;
		longint first, t;
		mon  = int'(rule[3:0]);
		wk   = int'(rule[6:4]);
		wd   = int'(rule[9:7]);
		mins = int'(rule[20:10]);
		if (mon < 1 || mon > 12 || wk < 1 || wk > 5 || wd > 6 || mins >= DAY_MINS)
			return 0;
		first = jan1;
		for (int m = 1; m < mon; m++)
			first += month_len(year, m);
		dow1 = int'((first + 4) % 7);
		dim  = int'(month_len(year, mon));
		day  = 1 + ((wd + 7 - dow1) % 7) + (wk - 1) * 7;
		while (day > dim)
			day -= 7;
		t = (first + day - 1) * DAY_SECS + mins * 60 - off * 60;
		return (t < 0) ? 0 : t;
	endfunction

	function automatic local_time_t convert_utc(input logic [31:0] utc_in);
		local_time_t r;
		longint utc, so, dso, off, days, d, year, s, e, loc;
		bit active;
		utc = utc_in;
		so = std_off;
		dso = dst_off;
		off = so;
		active = 0;
		if (dst_en && dso != so && dso >= -720 && dso <= 840) begin
			days = utc / DAY_SECS;
			d = days;
			year = 1970;
			while (d >= (leap_year(year) ? 366 : 365)) begin
				d -= leap_year(year) ? 366 : 365;
				year++;
			end
			s = rule_utc(year, days - d, rule_on, so);
			e = rule_utc(year, days - d, rule_off, dso);
			if (s != 0 && e != 0)
				active = (s < e) ? (utc >= s && utc < e) : (utc >= s || utc < e);
			if (active)
				off = dso;
		end
		// signed remainder: the sum may be negative
		loc = (utc + off * 60) % longint'(DAY_SECS);
		if (loc < 0)
			loc += longint'(DAY_SECS);
		r.hour   = 5'(loc / 3600);
		r.minute = 6'((loc % 3600) / 60);
		r.second = 6'(loc % 60);
		r.offset = off[10:0];
		r.active = active;
		return r;
	endfunction

	assign pending = expected_times.size();

	always @(posedge clk or negedge arst_n) begin
		local_time_t exp_t, got;
		if (!arst_n) begin
			std_off    <= '0;
			dst_off    <= '0;
			dst_en     <= 1'b0;
			rule_on    <= '0;
			rule_off   <= '0;
			fail_count <= 0;
			dst_hits   <= 0;
			expected_times.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STD_OFFSET: std_off    <= cfg_data[10:0];
					REG_DST_OFFSET: dst_off    <= cfg_data[10:0];
					REG_DST_ENABLE: dst_en     <= cfg_data[0];
					REG_DST_START:  rule_on    <= cfg_data;
					REG_DST_END:    rule_off   <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_times.push_back(convert_utc(s_tdata));
			// result words
			if (m_tvalid && m_tready) begin
				got = {m_tdata[4:0], m_tdata[10:5], m_tdata[16:11], m_tdata[27:17],
					m_tuser};
				if (expected_times.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					exp_t = expected_times.pop_front();
					if (got.active)
						dst_hits <= dst_hits + 1;
					if (got.hour !== exp_t.hour)
						$error("local_hour: expected %0d, got %0d", exp_t.hour, got.hour);
					if (got.minute !== exp_t.minute)
						$error("local_minute: expected %0d, got %0d", exp_t.minute,
							got.minute);
					if (got.second !== exp_t.second)
						$error("local_second: expected %0d, got %0d", exp_t.second,
							got.second);
					if (got.offset !== exp_t.offset)
						$error("offset: expected %0d, got %0d", exp_t.offset,
							got.offset);
					if (got.active !== exp_t.active)
						$error("dst_active: expected %0d, got %0d", exp_t.active,
							got.active);
					if (got !== exp_t)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

>>> sim/dst_local_time_converter_tb.sv
// Testbench top for the DST local time converter: clock, reset, stimulus and verdict.
// Depends on dlt_pkg, dlt_scoreboard and the block's RTL.
`timescale 1ns / 1ps
module dst_local_time_converter_tb;
	import dlt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [20:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	int          fail_count, pending, dst_hits;
	int          words_sent = 0;
	bit          hold_off = 0;
	bit          random_stall = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dst_local_time_converter u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser)
	);

	dlt_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .dst_hits(dst_hits)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		int wait_left;
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (!random_stall) begin
			m_tready <= 1'b1;
		end else if (wait_left > 0) begin
			wait_left = wait_left - 1;
			m_tready <= 1'b0;
		end else begin
			wait_left = gap_len();
			m_tready <= (wait_left == 0);
		end
	end

	// valid stays high; load_config drops it after the last register
	task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic send_word(input logic [31:0] utc, input bit gaps);
		int g;
		s_tvalid <= 1'b1;
		s_tdata  <= utc;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [20:0] make_rule(input int mon, input int wk, input int wd,
			input int mins);
		return {mins[10:0], wd[2:0], wk[2:0], mon[3:0]};
	endfunction

	// a valid rule most of the time, any bits otherwise
	function automatic logic [20:0] rand_rule();
		if ($urandom_range(0, 9) < 8)
			return make_rule($urandom_range(1, 12), $urandom_range(1, 5),
				$urandom_range(0, 6), $urandom_range(0, 1439));
		return 21'($urandom_range(0, 2097151));
	endfunction

	function automatic logic [10:0] rand_offset();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 11'h3FF;
		if (r == 1)
			return 11'h400;
		if (r == 2)
			return ($urandom_range(0, 1) != 0) ? 11'd840 : 11'h530;
		return 11'(int'($urandom_range(0, 1560)) - 720);
	endfunction

	task automatic load_config(input logic [10:0] so, input logic [10:0] dso,
			input bit en, input logic [20:0] sr, input logic [20:0] er);
		write_reg(REG_STD_OFFSET, {10'h0, so});
		write_reg(REG_DST_OFFSET, {10'h0, dso});
		write_reg(REG_DST_ENABLE, {20'h0, en});
		write_reg(REG_DST_START, sr);
		write_reg(REG_DST_END, er);
		cfg_valid <= 1'b0;
	endtask

	// random instants: a quarter fully random, the rest a random year step plus a point within a year
	task automatic random_words(input int n, input bit gaps);
		logic [31:0] u;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				u = $urandom();
			else
				u = $urandom_range(0, 200) * 32'd31556952 + $urandom_range(0, 31622400);
			send_word(u, gaps);
		end
	endtask

	initial begin
		logic [20:0] sr, er;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, field extremes
		send_word(32'd0, 0);
		send_word(32'hFFFFFFFF, 0);
		send_word(32'h80000000, 0);
		drain();

		// northern rule: March last Sunday 02:00 to October last Sunday 03:00
		sr = make_rule(3, 5, 0, 120);
		er = make_rule(10, 5, 0, 180);
		load_config(11'd60, 11'd120, 1, sr, er);
		send_word(32'd1711846800 - 1, 0);
		send_word(32'd1711846800, 0);
		send_word(32'd1729990800 - 1, 0);
		send_word(32'd1729990800, 0);
		send_word(32'd1720000000, 0);
		send_word(32'd951782400, 0);
		drain();
		// southern, wrapped: start October, end April
		load_config(11'd600, 11'd660, 1, make_rule(10, 1, 0, 120), make_rule(4, 1, 0, 180));
		send_word(32'd1704067200, 0);
		send_word(32'd1720000000, 0);
		send_word(32'd1735000000, 0);
		drain();
		// start equal to end, extremes of offsets, minute of day 1439
		load_config(11'h530, 11'd840, 1, make_rule(1, 1, 6, 1439), make_rule(1, 1, 6, 1439));
		send_word(32'd0, 0);
		send_word(32'd100000, 0);
		send_word(32'hFFFFFFFF, 0);
		drain();
		// invalid rule, equal offsets, out-of-range DST offset, rule at epoch
		load_config(11'd0, 11'd60, 1, make_rule(13, 1, 0, 0), make_rule(10, 5, 0, 180));
		send_word(32'd1720000000, 0);
		drain();
		load_config(11'd60, 11'd60, 1, sr, er);
		send_word(32'd1720000000, 0);
		drain();
		load_config(11'd60, 11'h3FF, 1, make_rule(1, 1, 7, 1440), make_rule(2, 0, 0, 0));
		send_word(32'd1720000000, 0);
		drain();
		load_config(11'd840, 11'h530, 1, make_rule(1, 1, 4, 0), make_rule(12, 5, 6, 0));
		send_word(32'd1000, 0);
		send_word(32'd40000, 0);
		drain();

		// random phases with fresh settings
		for (int ph = 0; ph < 24; ph++) begin
			load_config(rand_offset(), rand_offset(), $urandom_range(0, 5) != 0,
				rand_rule(), rand_rule());
			random_stall = (ph % 3 != 0);
			if (ph == 5) begin
				fork
					random_words(6, 0);
					begin
						hold_off = 1;
						repeat (2000) @(posedge clk);
						hold_off = 0;
					end
				join
			end
			random_words(50, ph % 4 != 1);
			drain();
		end

		$display("Sent %0d words over directed and 24 random settings; %0d with DST active.",
			words_sent, dst_hits);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
